### rtl/rpvg_pkg.sv
`default_nettype none
package rpvg_pkg;

    localparam int MAX_SIDES = 16;
    localparam int MIN_SIDES = 3;
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
    };

    typedef enum logic [2:0] {
        OP_EMIT  = 3'd0,
        OP_ROT   = 3'd1,
        OP_MOVE  = 3'd2,
        OP_SCALE = 3'd3,
        OP_LOAD  = 3'd4,
        OP_NOP   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        CFG_CX   = 3'd0,
        CFG_CY   = 3'd1,
        CFG_RAD  = 3'd2,
        CFG_ANG  = 3'd3,
        CFG_SIDE = 3'd4,
        CFG_RMIN = 3'd5,
        CFG_RMAX = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROT,
        S_MAP,
        S_MUL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [11:0]        rad;
        logic [15:0]        ang;
        logic [7:0]         sides;
        logic [11:0]        rmin;
        logic [11:0]        rmax;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic        zero_scale;
        logic [15:0] off_x;
        logic [15:0] off_y;
        logic [15:0] ang_off;
        logic [15:0] scale;
    } t_cmd;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [3:0]  idx;
        logic        last;
        logic        err;
    } t_res;

    // saturate a 17-bit signed sum to 16 bits
    function automatic logic [15:0] sat17(input logic [16:0] v);
        logic [15:0] r;
        if (v[16] != v[15]) begin
            r = v[16] ? 16'h8000 : 16'h7FFF;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [11:0] clamp_radius(input logic [19:0] v,
                                                 input logic [11:0] lo,
                                                 input logic [11:0] hi);
        logic [19:0] t;
        t = v;
        if (t < {8'd0, lo}) t = {8'd0, lo};
        if (t > {8'd0, hi}) t = {8'd0, hi};
        return t[11:0];
    endfunction

    // floor(65536 / n) for the clamped side count
    function automatic logic [15:0] step_quo(input logic [4:0] n);
        logic [15:0] q;
        case (n)
            5'd3:    q = 16'd21845;
            5'd4:    q = 16'd16384;
            5'd5:    q = 16'd13107;
            5'd6:    q = 16'd10922;
            5'd7:    q = 16'd9362;
            5'd8:    q = 16'd8192;
            5'd9:    q = 16'd7281;
            5'd10:   q = 16'd6553;
            5'd11:   q = 16'd5957;
            5'd12:   q = 16'd5461;
            5'd13:   q = 16'd5041;
            5'd14:   q = 16'd4681;
            5'd15:   q = 16'd4369;
            default: q = 16'd4096;
        endcase
        return q;
    endfunction

    // twice the remainder of 65536 / n
    function automatic logic [5:0] step_rem(input logic [4:0] n);
        logic [5:0] r;
        case (n)
            5'd3:    r = 6'd2;
            5'd5:    r = 6'd2;
            5'd6:    r = 6'd8;
            5'd7:    r = 6'd4;
            5'd9:    r = 6'd14;
            5'd10:   r = 6'd12;
            5'd11:   r = 6'd18;
            5'd12:   r = 6'd8;
            5'd13:   r = 6'd6;
            5'd14:   r = 6'd4;
            5'd15:   r = 6'd2;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/rpvg_fifo.sv
`default_nettype none
module rpvg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + CW'(wr_en) - CW'(rd_en);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule
`default_nettype wire

### rtl/rpvg_front.sv
`default_nettype none
module rpvg_front
    import rpvg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_offset_x,
    input  wire logic [15:0] i_offset_y,
    input  wire logic [15:0] i_angle_offset,
    input  wire logic [15:0] i_scale_factor,
    input  wire logic        i_pop,
    output t_cmd             o_cmd,
    output logic             o_empty
);
    t_cmd cmd_in;
    logic [$bits(t_cmd)-1:0] q_out;

    // decode the command code, unknown codes become no-ops
    always_comb begin
        cmd_in = '0;
        case (i_command)
            OP_EMIT:  cmd_in.op = OP_EMIT;
            OP_ROT:   cmd_in.op = OP_ROT;
            OP_MOVE:  cmd_in.op = OP_MOVE;
            OP_SCALE: cmd_in.op = OP_SCALE;
            OP_LOAD:  cmd_in.op = OP_LOAD;
            default:  cmd_in.op = OP_NOP;
        endcase
        cmd_in.zero_scale = (i_scale_factor == 16'd0);
        cmd_in.off_x      = i_offset_x;
        cmd_in.off_y      = i_offset_y;
        cmd_in.ang_off    = i_angle_offset;
        cmd_in.scale      = i_scale_factor;
    end

    rpvg_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cmd_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_data  (q_out),
        .o_empty (o_empty)
    );

    assign o_cmd = t_cmd'(q_out);
endmodule
`default_nettype wire

### rtl/rpvg_back.sv
`default_nettype none
module rpvg_back
    import rpvg_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_res      o_res
);
    t_state             r_state, n_state;
    logic signed [15:0] r_cx, n_cx;
    logic signed [15:0] r_cy, n_cy;
    logic [11:0]        r_rad, n_rad;
    logic [15:0]        r_ang, n_ang;
    logic [4:0]         r_n, n_n;
    logic [3:0]         r_k, n_k;
    logic [15:0]        r_step, n_step;
    logic [5:0]         r_rem, n_rem;
    logic [1:0]         r_quad, n_quad;
    logic signed [33:0] r_x, n_x;
    logic signed [33:0] r_y, n_y;
    logic signed [32:0] r_z, n_z;
    logic [3:0]         r_i, n_i;
    logic signed [15:0] r_sn, n_sn;
    logic signed [15:0] r_cs, n_cs;
    logic signed [28:0] r_px, n_px;
    logic signed [28:0] r_py, n_py;

    logic [4:0]         n_clamped;
    logic [15:0]        phase;
    logic [27:0]        scale_prod;
    logic [6:0]         rem_sum;
    logic signed [12:0] rad_s;
    logic signed [33:0] map_s, map_c;

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [19:0] q;
        logic signed [15:0] r;
        t = 35'(v) + 35'sd16384;
        q = t[34:15];
        if (q > 20'sd32767) begin
            r = 16'sh7FFF;
        end else if (q < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] place(input logic signed [15:0] c,
                                          input logic signed [28:0] p);
        logic signed [29:0] t;
        logic signed [14:0] off;
        t   = 30'(p) + 30'sd16384;
        off = t[29:15];
        return sat17({c[15], c} + {{2{off[14]}}, off});
    endfunction

    always_comb begin
        if (i_cfg.sides < 8'(MIN_SIDES)) begin
            n_clamped = 5'(MIN_SIDES);
        end else if (i_cfg.sides > 8'(MAX_SIDES)) begin
            n_clamped = 5'(MAX_SIDES);
        end else begin
            n_clamped = i_cfg.sides[4:0];
        end
    end

    assign phase      = 16'h8000 - r_ang + r_step;
    assign scale_prod = 28'(r_rad) * 28'(i_cmd.scale);
    assign rem_sum    = 7'(r_rem) + 7'(step_rem(r_n));
    assign rad_s      = {1'b0, r_rad};

    // fold the first-quadrant result into the phase quadrant
    always_comb begin
        case (r_quad)
            2'd0:    begin map_s = r_y;  map_c = r_x;  end
            2'd1:    begin map_s = r_x;  map_c = -r_y; end
            2'd2:    begin map_s = -r_y; map_c = -r_x; end
            default: begin map_s = -r_x; map_c = r_y;  end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cx = r_cx;  n_cy = r_cy;  n_rad = r_rad;  n_ang = r_ang;
        n_n = r_n;  n_k = r_k;  n_step = r_step;  n_rem = r_rem;
        n_quad = r_quad;  n_x = r_x;  n_y = r_y;  n_z = r_z;  n_i = r_i;
        n_sn = r_sn;  n_cs = r_cs;  n_px = r_px;  n_py = r_py;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_EMIT) begin
                        o_cmd_pop = 1'b1;
                        n_n       = n_clamped;
                        n_k       = '0;
                        n_step    = '0;
                        n_rem     = 6'(n_clamped);
                        n_state   = S_LOAD;
                    end else if (!i_res_full) begin
                        o_cmd_pop  = 1'b1;
                        o_res_push = 1'b1;
                        case (i_cmd.op)
                            OP_ROT: n_ang = r_ang + i_cmd.ang_off;
                            OP_MOVE: begin
                                n_cx = sat17({r_cx[15], r_cx} +
                                             {i_cmd.off_x[15], i_cmd.off_x});
                                n_cy = sat17({r_cy[15], r_cy} +
                                             {i_cmd.off_y[15], i_cmd.off_y});
                            end
                            OP_SCALE: begin
                                if (i_cmd.zero_scale) begin
                                    o_res.err = 1'b1;
                                end else begin
                                    n_rad = clamp_radius(scale_prod[27:8],
                                                         i_cfg.rmin, i_cfg.rmax);
                                end
                            end
                            OP_LOAD: begin
                                n_cx  = i_cfg.cx;
                                n_cy  = i_cfg.cy;
                                n_rad = clamp_radius({8'd0, i_cfg.rad},
                                                     i_cfg.rmin, i_cfg.rmax);
                                n_ang = i_cfg.ang;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_LOAD: begin
                n_quad  = phase[15:14];
                n_x     = CORDIC_GAIN;
                n_y     = '0;
                n_z     = {3'b000, phase[13:0], 16'd0};
                n_i     = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                if (!r_z[32]) begin
                    n_x = r_x - (r_y >>> r_i);
                    n_y = r_y + (r_x >>> r_i);
                    n_z = r_z - {1'b0, ATAN_TURN[r_i]};
                end else begin
                    n_x = r_x + (r_y >>> r_i);
                    n_y = r_y - (r_x >>> r_i);
                    n_z = r_z + {1'b0, ATAN_TURN[r_i]};
                end
                n_i = r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_sn    = to_q15(map_s);
                n_cs    = to_q15(map_c);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_px    = rad_s * r_sn;
                n_py    = rad_s * r_cs;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    o_res.x    = place(r_cx, r_px);
                    o_res.y    = place(r_cy, r_py);
                    o_res.idx  = r_k;
                    o_res.last = ({1'b0, r_k} == r_n - 5'd1);
                    if (o_res.last) begin
                        n_k     = '0;
                        n_state = S_IDLE;
                    end else begin
                        // next rounded step of one turn over n
                        n_k = r_k + 4'd1;
                        if (rem_sum >= {1'b0, r_n, 1'b0}) begin
                            n_rem  = 6'(rem_sum - {1'b0, r_n, 1'b0});
                            n_step = r_step + step_quo(r_n) + 16'd1;
                        end else begin
                            n_rem  = rem_sum[5:0];
                            n_step = r_step + step_quo(r_n);
                        end
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cx    <= '0;
            r_cy    <= '0;
            r_rad   <= 12'd64;
            r_ang   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_cx    <= n_cx;
            r_cy    <= n_cy;
            r_rad   <= n_rad;
            r_ang   <= n_ang;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_step <= n_step;
        r_rem  <= n_rem;
        r_quad <= n_quad;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_i    <= n_i;
        r_sn   <= n_sn;
        r_cs   <= n_cs;
        r_px   <= n_px;
        r_py   <= n_py;
    end
endmodule
`default_nettype wire

### rtl/regular_polygon_vertex_gen.sv
`default_nettype none
// regular polygon vertex generator: keeps a center, radius and rotation angle
// and executes one command per item (emit, rotate, move, scale, reload).
// emit returns n vertices (n = side_count clamped to 3..16), the last one
// marked; every other command returns one item with zero coordinates and
// last set, error set for a zero scale factor. commands enter a two-entry
// queue, so the source keeps pushing while the back end works; results leave
// through a two-entry queue, which holds results for a stalled consumer. a
// non-emit command is popped and answered in the same cycle. each vertex
// passes through phase setup, 16 cordic iterations on one shared shift-add
// unit, quadrant fold, multiply by radius and output. configuration
// registers are written through i_cfg_we / i_cfg_addr / i_cfg_data; the
// user must write them only while the block is idle; it does not check.
module regular_polygon_vertex_gen
    import rpvg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_offset_x,
    input  wire logic [15:0] i_offset_y,
    input  wire logic [15:0] i_angle_offset,
    input  wire logic [15:0] i_scale_factor,
    output logic             empty,
    input  wire logic        pop,
    output logic [15:0]      o_vertex_x,
    output logic [15:0]      o_vertex_y,
    output logic [3:0]       o_vertex_index,
    output logic             o_last,
    output logic             o_error,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_addr,
    input  wire logic [15:0] i_cfg_data
);
    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_empty;
    logic cmd_pop;
    logic res_full;
    logic res_push;
    t_res res_in;
    logic [$bits(t_res)-1:0] res_bits;
    t_res res_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cx    <= '0;
            r_cfg.cy    <= '0;
            r_cfg.rad   <= 12'd64;
            r_cfg.ang   <= '0;
            r_cfg.sides <= 8'd6;
            r_cfg.rmin  <= 12'd1;
            r_cfg.rmax  <= 12'd4095;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_CX:   r_cfg.cx    <= i_cfg_data;
                CFG_CY:   r_cfg.cy    <= i_cfg_data;
                CFG_RAD:  r_cfg.rad   <= i_cfg_data[11:0];
                CFG_ANG:  r_cfg.ang   <= i_cfg_data;
                CFG_SIDE: r_cfg.sides <= i_cfg_data[7:0];
                CFG_RMIN: r_cfg.rmin  <= i_cfg_data[11:0];
                CFG_RMAX: r_cfg.rmax  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // front: decode and queue commands
    rpvg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_command      (i_command),
        .i_offset_x     (i_offset_x),
        .i_offset_y     (i_offset_y),
        .i_angle_offset (i_angle_offset),
        .i_scale_factor (i_scale_factor),
        .i_pop          (cmd_pop),
        .o_cmd          (cmd),
        .o_empty        (cmd_empty)
    );

    // back: placement state and the vertex engine
    rpvg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (~cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    // result queue toward the consumer
    rpvg_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_bits),
        .o_empty (empty)
    );

    assign res_out        = t_res'(res_bits);
    assign o_vertex_x     = res_out.x;
    assign o_vertex_y     = res_out.y;
    assign o_vertex_index = res_out.idx;
    assign o_last         = res_out.last;
    assign o_error        = res_out.err;
endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top
    import rpvg_pkg::*;
;

    // cordic step angles in 32-bit turn units
    localparam longint STEP_ANGLE [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };
    localparam longint GAIN_START = 64'd652032875;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  i_command = '0;
    logic [15:0] i_offset_x = '0;
    logic [15:0] i_offset_y = '0;
    logic [15:0] i_angle_offset = '0;
    logic [15:0] i_scale_factor = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_vertex_x;
    logic [15:0] o_vertex_y;
    logic [3:0]  o_vertex_index;
    logic        o_last;
    logic        o_error;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [15:0] i_cfg_data = '0;

    regular_polygon_vertex_gen dut (.*);

    // clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // command item as the table and random part hand it over
    typedef struct {
        logic [2:0]  op;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] da;
        logic [15:0] sf;
    } t_cmd_item;

    // one directed row: the item and, where obvious, its single result
    typedef struct {
        t_cmd_item   item;
        logic        known;
        logic [15:0] ex;
        logic [15:0] ey;
        logic        eerr;
    } t_dir_row;

    // shadow copy of the configuration registers
    longint shd_cx, shd_cy;
    int     shd_rad, shd_ang, shd_sides, shd_rmin, shd_rmax;
    // shadow copy of the polygon placement
    longint poly_cx, poly_cy;
    int     poly_rad, poly_ang;

    t_res   vertex_queue[$];
    int     fail_count = 0;
    int     vertex_seen = 0;
    int     items_sent = 0;
    int     emits_sent = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     stim_done = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // append one expected result item
    function automatic void expect_res(input t_res r);
        vertex_queue.insert(vertex_queue.size(), r);
    endfunction

    function automatic longint flr_shr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint sat16(input longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    function automatic int radius_clamp(input longint v);
        if (v < shd_rmin) v = shd_rmin;
        if (v > shd_rmax) v = shd_rmax;
        return int'(v);
    endfunction

    // sine and cosine in q1.15 for a 16-bit turn fraction
    task automatic phase_sincos(input int ph, output longint sn, output longint cs);
        longint z32, z, x, y, dx, dy, s, c;
        int q;
        z32 = longint'(ph) << 16;
        q = int'(z32 >> 30);
        z = z32 & 64'h3FFFFFFF;
        x = GAIN_START;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = flr_shr(y, i);
            dy = flr_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= STEP_ANGLE[i];
            end else begin
                x += dx; y -= dy; z += STEP_ANGLE[i];
            end
        end
        case (q)
            0: begin s = y;  c = x;  end
            1: begin s = x;  c = -y; end
            2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
        sn = flr_shr(s + 16384, 15);
        sn = sn > 32767 ? 32767 : (sn < -32768 ? -32768 : sn);
        cs = flr_shr(c + 16384, 15);
        cs = cs > 32767 ? 32767 : (cs < -32768 ? -32768 : cs);
    endtask

    function automatic t_res plain_result(input logic err);
        t_res r;
        r = '0;
        r.last = 1'b1;
        r.err = err;
        return r;
    endfunction

    // predict the vertices of one command and update the placement
    task automatic predict_vertices(input t_cmd_item c);
        t_res   r;
        int     n, stp, ph;
        longint sn, cs;
        case (c.op)
            OP_EMIT: begin
                n = shd_sides < MIN_SIDES ? MIN_SIDES
                  : (shd_sides > MAX_SIDES ? MAX_SIDES : shd_sides);
                for (int k = 0; k < n; k++) begin
                    stp = int'((longint'(k) * 131072 + n) / (2 * n));
                    ph = (32768 - poly_ang + stp) & 16'hFFFF;
                    phase_sincos(ph, sn, cs);
                    r = '0;
                    r.x = 16'(sat16(poly_cx + flr_shr(poly_rad * sn + 16384, 15)));
                    r.y = 16'(sat16(poly_cy + flr_shr(poly_rad * cs + 16384, 15)));
                    r.idx = 4'(k);
                    r.last = (k == n - 1);
                    expect_res(r);
                end
            end
            OP_ROT: begin
                poly_ang = (poly_ang + c.da) & 16'hFFFF;
                expect_res(plain_result(1'b0));
            end
            OP_MOVE: begin
                poly_cx = sat16(poly_cx + longint'($signed(c.dx)));
                poly_cy = sat16(poly_cy + longint'($signed(c.dy)));
                expect_res(plain_result(1'b0));
            end
            OP_SCALE: begin
                if (c.sf == 0) begin
                    expect_res(plain_result(1'b1));
                end else begin
                    poly_rad = radius_clamp((longint'(poly_rad) * c.sf) >> 8);
                    expect_res(plain_result(1'b0));
                end
            end
            OP_LOAD: begin
                poly_cx = shd_cx;
                poly_cy = shd_cy;
                poly_rad = radius_clamp(shd_rad);
                poly_ang = shd_ang;
                expect_res(plain_result(1'b0));
            end
            default: expect_res(plain_result(1'b0));
        endcase
    endtask

    // hand one item over, with random gaps before it
    task automatic send_item(input t_cmd_item c);
        i_cfg_we <= 1'b0;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_command <= c.op;
        i_offset_x <= c.dx;
        i_offset_y <= c.dy;
        i_angle_offset <= c.da;
        i_scale_factor <= c.sf;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predict_vertices(c);
        items_sent++;
        if (c.op == OP_EMIT) emits_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (vertex_queue.size() != 0) @(negedge i_clk);
        // an emit in flight has no result pending past the last one
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        case (idx)
            CFG_CX:   shd_cx = longint'($signed(val));
            CFG_CY:   shd_cy = longint'($signed(val));
            CFG_RAD:  shd_rad = val[11:0];
            CFG_ANG:  shd_ang = val;
            CFG_SIDE: shd_sides = val[7:0];
            CFG_RMIN: shd_rmin = val[11:0];
            default:  shd_rmax = val[11:0];
        endcase
    endtask

    function automatic t_cmd_item mk(input logic [2:0] op, input logic [15:0] dx,
                                     input logic [15:0] dy, input logic [15:0] da,
                                     input logic [15:0] sf);
        t_cmd_item c;
        c.op = op; c.dx = dx; c.dy = dy; c.da = da; c.sf = sf;
        return c;
    endfunction

    function automatic t_cmd_item rand_item(input bit well_formed);
        t_cmd_item c;
        int pick;
        c.dx = 16'($urandom);
        c.dy = 16'($urandom);
        c.da = 16'($urandom);
        c.sf = 16'($urandom);
        pick = $urandom_range(99);
        if (!well_formed) c.op = 3'($urandom_range(7));
        else if (pick < 35) c.op = OP_EMIT;
        else if (pick < 55) c.op = OP_ROT;
        else if (pick < 72) c.op = OP_MOVE;
        else if (pick < 90) c.op = OP_SCALE;
        else c.op = OP_LOAD;
        // keep most scales near unity so the radius wanders instead of pinning
        if (c.op == OP_SCALE && $urandom_range(3) != 0) c.sf = 16'($urandom_range(128, 400));
        if (c.op == OP_SCALE && $urandom_range(15) == 0) c.sf = 16'd0;
        if (c.op == OP_MOVE && $urandom_range(1)) begin
            c.dx = 16'($signed(10'($urandom)));
            c.dy = 16'($signed(10'($urandom)));
        end
        return c;
    endfunction

    // result side: pop with random stalls, compare against the oldest vertex
    always @(negedge i_clk) begin
        pop <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_res w;
        if (i_rst_n && pop && !empty) begin
            if (vertex_queue.size() == 0) begin
                report_mismatch("unexpected item, index", o_vertex_index, -1);
            end else begin
                w = vertex_queue.pop_front();
                vertex_seen++;
                if (o_vertex_x !== w.x)
                    report_mismatch("vertex_x", $signed(o_vertex_x), $signed(w.x));
                if (o_vertex_y !== w.y)
                    report_mismatch("vertex_y", $signed(o_vertex_y), $signed(w.y));
                if (o_vertex_index !== w.idx)
                    report_mismatch("vertex_index", o_vertex_index, w.idx);
                if (o_last !== w.last) report_mismatch("last", o_last, w.last);
                if (o_error !== w.err) report_mismatch("error", o_error, w.err);
            end
        end
    end

    // directed rows; known results typed in only for single-item commands
    t_dir_row dir_rows[$];

    task automatic add_row(input t_cmd_item c, input logic known, input logic eerr);
        t_dir_row r;
        r.item = c; r.known = known; r.ex = '0; r.ey = '0; r.eerr = eerr;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    initial begin
        t_cmd_item c;
        int phase_cfg;
        shd_cx = 0; shd_cy = 0; shd_rad = 64; shd_ang = 0;
        shd_sides = 6; shd_rmin = 1; shd_rmax = 4095;
        poly_cx = 0; poly_cy = 0; poly_rad = 64; poly_ang = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset placement, every command, field extremes
        add_row(mk(OP_EMIT, 0, 0, 0, 0), 1'b0, 1'b0);
        add_row(mk(OP_ROT, 0, 0, 16'hFFFF, 0), 1'b1, 1'b0);
        add_row(mk(OP_ROT, 0, 0, 16'h0001, 0), 1'b1, 1'b0);
        add_row(mk(OP_SCALE, 0, 0, 0, 16'd0), 1'b1, 1'b1);
        add_row(mk(OP_SCALE, 0, 0, 0, 16'hFFFF), 1'b1, 1'b0);
        add_row(mk(OP_EMIT, 0, 0, 0, 0), 1'b0, 1'b0);
        add_row(mk(OP_MOVE, 16'h7FFF, 16'h8000, 0, 0), 1'b1, 1'b0);
        add_row(mk(OP_MOVE, 16'h7FFF, 16'h8000, 0, 0), 1'b1, 1'b0);
        add_row(mk(OP_EMIT, 0, 0, 0, 0), 1'b0, 1'b0);
        add_row(mk(OP_SCALE, 0, 0, 0, 16'h0001), 1'b1, 1'b0);
        add_row(mk(OP_EMIT, 0, 0, 0, 0), 1'b0, 1'b0);
        add_row(mk(3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b1, 1'b0);
        add_row(mk(3'd6, 0, 0, 0, 0), 1'b1, 1'b0);
        add_row(mk(3'd7, 0, 0, 0, 0), 1'b1, 1'b0);
        add_row(mk(OP_LOAD, 0, 0, 0, 0), 1'b1, 1'b0);
        add_row(mk(OP_MOVE, 16'h8000, 16'h7FFF, 0, 0), 1'b1, 1'b0);
        add_row(mk(OP_ROT, 0, 0, 16'h4000, 0), 1'b1, 1'b0);
        add_row(mk(OP_EMIT, 0, 0, 0, 0), 1'b0, 1'b0);

        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].item);
            // for single-item commands the expectation is zeros with last set
            if (dir_rows[i].known) begin
                vertex_queue[vertex_queue.size() - 1].x = dir_rows[i].ex;
                vertex_queue[vertex_queue.size() - 1].y = dir_rows[i].ey;
                vertex_queue[vertex_queue.size() - 1].err = dir_rows[i].eerr;
            end
        end
        wait_drained();

        // random phases: each with its own register setting and one of four idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            wait_drained();
            phase_cfg = ph;
            case (phase_cfg)
                0: begin
                    write_reg(CFG_SIDE, 16'd0);
                    write_reg(CFG_RMIN, 16'd0);
                    write_reg(CFG_RMAX, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_SIDE, 16'd255);
                    write_reg(CFG_CX, 16'h7FFF);
                    write_reg(CFG_CY, 16'h8000);
                    write_reg(CFG_RAD, 16'hFFFF);
                    write_reg(CFG_ANG, 16'hFFFF);
                end
                2: begin
                    write_reg(CFG_SIDE, 16'd16);
                    write_reg(CFG_RMIN, 16'd2000);
                    write_reg(CFG_RMAX, 16'd100);
                end
                3: begin
                    write_reg(CFG_SIDE, 16'd3);
                    write_reg(CFG_RMIN, 16'd1);
                    write_reg(CFG_RMAX, 16'd4095);
                    write_reg(CFG_RAD, 16'd0);
                end
                default: begin
                    write_reg(CFG_SIDE, 16'($urandom_range(2, 17)));
                    write_reg(CFG_CX, 16'($urandom));
                    write_reg(CFG_CY, 16'($urandom));
                    write_reg(CFG_RAD, 16'($urandom));
                    write_reg(CFG_ANG, 16'($urandom));
                    write_reg(CFG_RMIN, 16'($urandom_range(0, 200)));
                    write_reg(CFG_RMAX, 16'($urandom_range(100, 4095)));
                end
            endcase
            send_item(mk(OP_LOAD, 0, 0, 0, 0));
            for (int n = 0; n < 42; n++) begin
                c = rand_item($urandom_range(9) != 0);
                send_item(c);
                // pause once per phase until all vertices are out
                if (n == 20) wait_drained();
            end
        end

        wait_drained();
        stim_done = 1'b1;
        repeat (50) @(negedge i_clk);
        $display("run covered %0d items, %0d of them emits, %0d result items checked",
                 items_sent, emits_sent, vertex_seen);
        $display("eight register settings including clamp extremes, four idling mixes");
        if (fail_count == 0 && vertex_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("timeout with %0d items still expected", vertex_queue.size());
        $display("status: fail");
        $finish;
    end

endmodule
